// ===== hdl/bfu_pkg.sv =====
// Boid flocking update: shared types, constants and arithmetic helpers.
// Used by the channel interfaces and every module of the block.
package bfu_pkg;

    localparam int POS_W   = 24;
    localparam int RAD_W   = 16;
    localparam int DT_W    = 16;
    localparam int WIN_W   = 15;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 11;
    localparam int VEC_W   = 42;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] MAX_NEIGHBORS = 11'd1024;
    localparam logic [9:0]  SEP_MIN_DSQ = 10'd655;
    localparam logic [13:0] PUSH_SPEED  = 14'd12800;
    localparam logic [13:0] PULL_UNIT   = 14'd256;
    localparam logic signed [16:0] KEEP_GAIN  = 17'sd45875;
    localparam logic signed [16:0] BLEND_GAIN = 17'sd19661;
    localparam logic [WIN_W-1:0] WIDTH_RST  = 15'd800;
    localparam logic [WIN_W-1:0] HEIGHT_RST = 15'd600;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    // divider: 57-bit dividend, 38-bit divisor, quotient known below 2^29
    localparam int DIV_NUM_W = 57;
    localparam int DIV_DEN_W = 38;
    localparam int DIV_Q_W   = 29;
    // square root: 62-bit radicand, 31-bit root
    localparam int SQ_W      = 62;
    localparam int ROOT_W    = 31;

    localparam logic KIND_SUBJECT  = 1'b0;
    localparam logic KIND_NEIGHBOR = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic [RAD_W-1:0]        size_radius;
        logic [DT_W-1:0]         step_time;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] new_pos_x;
        logic signed [POS_W-1:0] new_pos_y;
        logic signed [POS_W-1:0] new_vel_x;
        logic signed [POS_W-1:0] new_vel_y;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        logic     is_subject;
        t_in_item item;
    } t_qlink;

    function automatic logic signed [SUM_W-1:0] sat40(input logic signed [SUM_W:0] v);
        if (v[SUM_W] != v[SUM_W-1]) begin
            return v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return v[SUM_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [VEC_W-1:0] v);
        if (v > $signed(42'sd8388607)) begin
            return 24'sh7FFFFF;
        end else if (v < -$signed(42'sd8388608)) begin
            return 24'sh800000;
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] wrap_coord(input logic signed [25:0] p,
                                                           input logic [WIN_W-1:0] win);
        logic signed [25:0] lim;
        lim = $signed({3'b000, win, 8'h00});
        if (p <= 26'sd0) begin
            return lim[POS_W-1:0];
        end else if (p >= lim) begin
            return '0;
        end
        return p[POS_W-1:0];
    endfunction

endpackage

// ===== hdl/bfu_in_if.sv =====
// Input channel of the boid flocking update: valid/ready plus one item.
// Depends on bfu_pkg.
interface bfu_in_if;
    import bfu_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/bfu_out_if.sv =====
// Result channel of the boid flocking update: valid/ready plus one result.
// Depends on bfu_pkg.
interface bfu_out_if;
    import bfu_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/bfu_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, two dividends
// over one shared divisor. Depends on bfu_pkg.
module bfu_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [bfu_pkg::DIV_NUM_W-1:0]   i_num_x,
    input  logic [bfu_pkg::DIV_NUM_W-1:0]   i_num_y,
    input  logic [bfu_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                            o_done,
    output logic [bfu_pkg::DIV_Q_W-1:0]     o_q_x,
    output logic [bfu_pkg::DIV_Q_W-1:0]     o_q_y
);
    import bfu_pkg::*;

    logic                 r_busy, r_done;
    logic [4:0]           r_cnt;
    logic [DIV_DEN_W-1:0] r_den, r_rem_x, r_rem_y;
    logic [DIV_Q_W-1:0]   r_lo_x, r_lo_y, r_q_x, r_q_y;
    logic [DIV_DEN_W:0]   t_x, t_y;
    logic                 ge_x, ge_y;

    assign t_x  = {r_rem_x, r_lo_x[DIV_Q_W-1]};
    assign t_y  = {r_rem_y, r_lo_y[DIV_Q_W-1]};
    assign ge_x = t_x >= {1'b0, r_den};
    assign ge_y = t_y >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den   <= i_den;
            r_rem_x <= DIV_DEN_W'(i_num_x[DIV_NUM_W-1:DIV_Q_W]);
            r_rem_y <= DIV_DEN_W'(i_num_y[DIV_NUM_W-1:DIV_Q_W]);
            r_lo_x  <= i_num_x[DIV_Q_W-1:0];
            r_lo_y  <= i_num_y[DIV_Q_W-1:0];
            r_q_x   <= '0;
            r_q_y   <= '0;
        end else if (r_busy) begin
            r_rem_x <= ge_x ? DIV_DEN_W'(t_x - {1'b0, r_den}) : t_x[DIV_DEN_W-1:0];
            r_rem_y <= ge_y ? DIV_DEN_W'(t_y - {1'b0, r_den}) : t_y[DIV_DEN_W-1:0];
            r_lo_x  <= {r_lo_x[DIV_Q_W-2:0], 1'b0};
            r_lo_y  <= {r_lo_y[DIV_Q_W-2:0], 1'b0};
            r_q_x   <= {r_q_x[DIV_Q_W-2:0], ge_x};
            r_q_y   <= {r_q_y[DIV_Q_W-2:0], ge_y};
        end
    end

    assign o_done = r_done;
    assign o_q_x  = r_q_x;
    assign o_q_y  = r_q_y;
endmodule

// ===== hdl/bfu_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on bfu_pkg.
module bfu_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bfu_pkg::SQ_W-1:0]     i_n,
    output logic                         o_done,
    output logic [bfu_pkg::ROOT_W-1:0]   o_root
);
    import bfu_pkg::*;

    logic            r_busy, r_done;
    logic [SQ_W-1:0] r_n, r_r, r_bit, t_sum;

    assign t_sum = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_r   <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_busy) begin
            if (r_n >= t_sum) begin
                r_n <= r_n - t_sum;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];
endmodule

// ===== hdl/bfu_front.sv =====
// Front end: takes input transfers, tags subject versus neighbor items and
// holds them in a two-entry queue for the back end. Depends on bfu_pkg, bfu_in_if.
module bfu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bfu_in_if.sink           i_in,
    output bfu_pkg::t_qlink  o_link,
    input  logic             i_pop
);
    import bfu_pkg::*;

    t_in_item   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push = i_in.valid && i_in.ready;
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in.data;
        end
    end

    assign o_link.valid      = (r_cnt != 2'd0);
    assign o_link.item       = r_q[r_rp];
    assign o_link.is_subject = (r_q[r_rp].kind == KIND_SUBJECT);
endmodule

// ===== hdl/bfu_back.sv =====
// Back end: subject move and wrap, neighbor accumulation, final velocity
// update and the result register. Depends on bfu_pkg, bfu_out_if, bfu_div, bfu_sqrt.
module bfu_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bfu_pkg::t_qlink                 i_link,
    output logic                            o_pop,
    input  logic                            i_cfg_we,
    input  logic [bfu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfu_pkg::WIN_W-1:0]       i_cfg_data,
    bfu_out_if.source                       o_out
);
    import bfu_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_MOVE   = 5'd1;
    localparam logic [4:0] ST_WRAP   = 5'd2;
    localparam logic [4:0] ST_NDIFF  = 5'd3;
    localparam logic [4:0] ST_NSQ    = 5'd4;
    localparam logic [4:0] ST_NTEST  = 5'd5;
    localparam logic [4:0] ST_NDIV   = 5'd6;
    localparam logic [4:0] ST_FSTART = 5'd7;
    localparam logic [4:0] ST_FGRP   = 5'd8;
    localparam logic [4:0] ST_FCOH1  = 5'd9;
    localparam logic [4:0] ST_FCOH2  = 5'd10;
    localparam logic [4:0] ST_ULOAD  = 5'd11;
    localparam logic [4:0] ST_UNORM  = 5'd12;
    localparam logic [4:0] ST_USQ    = 5'd13;
    localparam logic [4:0] ST_UROOT  = 5'd14;
    localparam logic [4:0] ST_UROOTW = 5'd15;
    localparam logic [4:0] ST_UDIVW  = 5'd16;
    localparam logic [4:0] ST_APPLY  = 5'd17;
    localparam logic [4:0] ST_SEP2   = 5'd18;
    localparam logic [4:0] ST_OUT    = 5'd19;

    localparam logic [1:0] PH_SEP  = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_COH  = 2'd2;

    logic [4:0]              r_state;
    t_in_item                r_it;
    logic [WIN_W-1:0]        r_win_w, r_win_h;
    logic signed [POS_W-1:0] r_spx, r_spy, r_svx, r_svy, r_vx, r_vy;
    logic [RAD_W-1:0]        r_srad;
    logic signed [SUM_W-1:0] r_sep_x, r_sep_y, r_hd_x, r_hd_y, r_ct_x, r_ct_y;
    logic [CNT_W-1:0]        r_sep_cnt, r_grp_cnt;
    logic signed [40:0]      r_mx, r_my, r_p1x, r_p1y, r_p2x, r_p2y;
    logic [24:0]             r_adx, r_ady;
    logic                    r_ndx, r_ndy;
    logic [18:0]             r_md, r_gr;
    logic [50:0]             r_dsq;
    logic [37:0]             r_mdsq, r_grsq;
    logic [1:0]              r_phase;
    logic signed [VEC_W-1:0] r_wx, r_wy;
    logic [VEC_W-1:0]        r_ux, r_uy;
    logic                    r_negx, r_negy;
    logic [13:0]             r_gain;
    logic [59:0]             r_sqx, r_sqy;
    logic [43:0]             r_gx, r_gy;
    logic signed [15:0]      r_ax, r_ay;
    logic signed [35:0]      r_cpx, r_cpy;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic signed [24:0]      dx, dy;
    logic signed [25:0]      mvx, mvy;
    logic signed [VEC_W-1:0] bx, by;
    logic signed [29:0]      sx, sy;
    logic                    sep_hit, grp_hit;
    logic                    d_start, d_done, sq_done;
    logic [DIV_NUM_W-1:0]    d_num_x, d_num_y;
    logic [DIV_DEN_W-1:0]    d_den;
    logic [DIV_Q_W-1:0]      q_x, q_y;
    logic [ROOT_W-1:0]       sq_root;
    logic                    out_free;

    assign dx = 25'(r_spx) - 25'(r_it.pos_x);
    assign dy = 25'(r_spy) - 25'(r_it.pos_y);
    assign mvx = 26'(r_it.pos_x) + 26'((r_mx + 41'sd32768) >>> 16);
    assign mvy = 26'(r_it.pos_y) + 26'((r_my + 41'sd32768) >>> 16);
    assign bx = (42'(r_p1x) + 42'(r_p2x) + 42'sd32768) >>> 16;
    assign by = (42'(r_p1y) + 42'(r_p2y) + 42'sd32768) >>> 16;
    assign sx = r_ndx ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    assign sy = r_ndy ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});

    assign sep_hit = (r_dsq < 51'(r_mdsq)) && (r_dsq > 51'(SEP_MIN_DSQ))
                  && (r_sep_cnt < MAX_NEIGHBORS);
    assign grp_hit = (r_dsq <= 51'(r_grsq)) && (r_grp_cnt < MAX_NEIGHBORS);

    assign d_start = (r_state == ST_NTEST && sep_hit)
                  || (r_state == ST_UROOTW && sq_done && sq_root != '0);
    assign d_num_x = (r_state == ST_NTEST) ? {r_adx, 32'd0} : DIV_NUM_W'(r_gx);
    assign d_num_y = (r_state == ST_NTEST) ? {r_ady, 32'd0} : DIV_NUM_W'(r_gy);
    assign d_den   = (r_state == ST_NTEST) ? r_dsq[DIV_DEN_W-1:0] : DIV_DEN_W'(sq_root);

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == ST_IDLE) && i_link.valid;

    bfu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num_x (d_num_x),
        .i_num_y (d_num_y),
        .i_den   (d_den),
        .o_done  (d_done),
        .o_q_x   (q_x),
        .o_q_y   (q_y)
    );

    bfu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_UROOT),
        .i_n     (SQ_W'(r_sqx) + SQ_W'(r_sqy)),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_win_w     <= WIDTH_RST;
            r_win_h     <= HEIGHT_RST;
            r_spx       <= '0;
            r_spy       <= '0;
            r_svx       <= '0;
            r_svy       <= '0;
            r_srad      <= '0;
            r_sep_x     <= '0;
            r_sep_y     <= '0;
            r_hd_x      <= '0;
            r_hd_y      <= '0;
            r_ct_x      <= '0;
            r_ct_y      <= '0;
            r_sep_cnt   <= '0;
            r_grp_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WIDTH:  r_win_w <= i_cfg_data;
                    REG_HEIGHT: r_win_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && o_out.ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_link.valid) begin
                        r_it    <= i_link.item;
                        r_state <= i_link.is_subject ? ST_MOVE : ST_NDIFF;
                    end
                end
                ST_MOVE: begin
                    r_mx    <= r_it.vel_x * $signed({1'b0, r_it.step_time});
                    r_my    <= r_it.vel_y * $signed({1'b0, r_it.step_time});
                    r_state <= ST_WRAP;
                end
                ST_WRAP: begin
                    r_spx     <= wrap_coord(mvx, r_win_w);
                    r_spy     <= wrap_coord(mvy, r_win_h);
                    r_svx     <= r_it.vel_x;
                    r_svy     <= r_it.vel_y;
                    r_srad    <= r_it.size_radius;
                    r_sep_x   <= '0;
                    r_sep_y   <= '0;
                    r_hd_x    <= '0;
                    r_hd_y    <= '0;
                    r_ct_x    <= '0;
                    r_ct_y    <= '0;
                    r_sep_cnt <= '0;
                    r_grp_cnt <= '0;
                    r_state   <= r_it.last ? ST_FSTART : ST_IDLE;
                end
                ST_NDIFF: begin
                    r_adx   <= dx[24] ? 25'(-dx) : 25'(dx);
                    r_ady   <= dy[24] ? 25'(-dy) : 25'(dy);
                    r_ndx   <= dx[24];
                    r_ndy   <= dy[24];
                    r_md    <= 19'(({1'b0, r_srad} + {1'b0, r_it.size_radius}) * 19'd3);
                    r_gr    <= 19'(r_srad * 19'd5);
                    r_state <= ST_NSQ;
                end
                ST_NSQ: begin
                    r_dsq   <= r_adx * r_adx + r_ady * r_ady;
                    r_mdsq  <= r_md * r_md;
                    r_grsq  <= r_gr * r_gr;
                    r_state <= ST_NTEST;
                end
                ST_NTEST: begin
                    if (grp_hit) begin
                        r_hd_x    <= sat40(41'(r_hd_x) + 41'(r_it.vel_x));
                        r_hd_y    <= sat40(41'(r_hd_y) + 41'(r_it.vel_y));
                        r_ct_x    <= sat40(41'(r_ct_x) + 41'(r_it.pos_x));
                        r_ct_y    <= sat40(41'(r_ct_y) + 41'(r_it.pos_y));
                        r_grp_cnt <= r_grp_cnt + 11'd1;
                    end
                    if (sep_hit) begin
                        r_state <= ST_NDIV;
                    end else begin
                        r_state <= r_it.last ? ST_FSTART : ST_IDLE;
                    end
                end
                ST_NDIV: begin
                    if (d_done) begin
                        r_sep_x   <= sat40(41'(r_sep_x) + 41'(sx));
                        r_sep_y   <= sat40(41'(r_sep_y) + 41'(sy));
                        r_sep_cnt <= r_sep_cnt + 11'd1;
                        r_state   <= r_it.last ? ST_FSTART : ST_IDLE;
                    end
                end
                ST_FSTART: begin
                    r_vx <= r_svx;
                    r_vy <= r_svy;
                    if (r_sep_cnt != '0) begin
                        r_wx    <= 42'(r_sep_x);
                        r_wy    <= 42'(r_sep_y);
                        r_gain  <= PUSH_SPEED;
                        r_phase <= PH_SEP;
                        r_state <= ST_ULOAD;
                    end else begin
                        r_state <= ST_FGRP;
                    end
                end
                ST_FGRP: begin
                    if (r_grp_cnt != '0) begin
                        r_wx    <= 42'(r_hd_x);
                        r_wy    <= 42'(r_hd_y);
                        r_gain  <= PUSH_SPEED;
                        r_phase <= PH_HEAD;
                        r_state <= ST_ULOAD;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_FCOH1: begin
                    r_cpx   <= $signed({1'b0, r_grp_cnt}) * r_spx;
                    r_cpy   <= $signed({1'b0, r_grp_cnt}) * r_spy;
                    r_state <= ST_FCOH2;
                end
                ST_FCOH2: begin
                    r_wx    <= 42'(r_ct_x) - 42'(r_cpx);
                    r_wy    <= 42'(r_ct_y) - 42'(r_cpy);
                    r_gain  <= PULL_UNIT;
                    r_phase <= PH_COH;
                    r_state <= ST_ULOAD;
                end
                ST_ULOAD: begin
                    r_ux    <= r_wx[VEC_W-1] ? VEC_W'(-r_wx) : VEC_W'(r_wx);
                    r_uy    <= r_wy[VEC_W-1] ? VEC_W'(-r_wy) : VEC_W'(r_wy);
                    r_negx  <= r_wx[VEC_W-1];
                    r_negy  <= r_wy[VEC_W-1];
                    r_state <= ST_UNORM;
                end
                ST_UNORM: begin
                    if (r_ux[VEC_W-1:30] != '0 || r_uy[VEC_W-1:30] != '0) begin
                        r_ux <= r_ux >> 1;
                        r_uy <= r_uy >> 1;
                    end else begin
                        r_state <= ST_USQ;
                    end
                end
                ST_USQ: begin
                    r_sqx   <= r_ux[29:0] * r_ux[29:0];
                    r_sqy   <= r_uy[29:0] * r_uy[29:0];
                    r_gx    <= r_ux[29:0] * r_gain;
                    r_gy    <= r_uy[29:0] * r_gain;
                    r_state <= ST_UROOT;
                end
                ST_UROOT: begin
                    r_state <= ST_UROOTW;
                end
                ST_UROOTW: begin
                    if (sq_done) begin
                        if (sq_root == '0) begin
                            r_ax    <= '0;
                            r_ay    <= '0;
                            r_state <= ST_APPLY;
                        end else begin
                            r_state <= ST_UDIVW;
                        end
                    end
                end
                ST_UDIVW: begin
                    if (d_done) begin
                        r_ax    <= r_negx ? -$signed({1'b0, q_x[14:0]})
                                          : $signed({1'b0, q_x[14:0]});
                        r_ay    <= r_negy ? -$signed({1'b0, q_y[14:0]})
                                          : $signed({1'b0, q_y[14:0]});
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    unique case (r_phase)
                        PH_SEP: begin
                            r_p1x   <= r_vx * KEEP_GAIN;
                            r_p1y   <= r_vy * KEEP_GAIN;
                            r_p2x   <= r_ax * BLEND_GAIN;
                            r_p2y   <= r_ay * BLEND_GAIN;
                            r_state <= ST_SEP2;
                        end
                        PH_HEAD: begin
                            r_vx    <= sat24(42'(r_vx) + 42'(r_ax));
                            r_vy    <= sat24(42'(r_vy) + 42'(r_ay));
                            r_state <= ST_FCOH1;
                        end
                        default: begin
                            r_vx    <= sat24(42'(r_vx) + 42'(r_ax));
                            r_vy    <= sat24(42'(r_vy) + 42'(r_ay));
                            r_state <= ST_OUT;
                        end
                    endcase
                end
                ST_SEP2: begin
                    r_vx    <= sat24(bx);
                    r_vy    <= sat24(by);
                    r_state <= ST_FGRP;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out.new_pos_x <= r_spx;
                        r_out.new_pos_y <= r_spy;
                        r_out.new_vel_x <= r_vx;
                        r_out.new_vel_y <= r_vy;
                        r_out_valid     <= 1'b1;
                        r_sep_x         <= '0;
                        r_sep_y         <= '0;
                        r_hd_x          <= '0;
                        r_hd_y          <= '0;
                        r_ct_x          <= '0;
                        r_ct_y          <= '0;
                        r_sep_cnt       <= '0;
                        r_grp_cnt       <= '0;
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

// ===== hdl/boid_flocking_update_top.sv =====
// Boid flocking update, top level: front queue plus back-end datapath.
// Depends on bfu_pkg, bfu_in_if, bfu_out_if, bfu_front, bfu_back.
//
// Usage:
//   i_in carries items. A subject item (kind 0) moves and wraps one boid
//   and starts a round; neighbor items (kind 1) feed the separation,
//   heading and center sums. The item with last set closes the round and
//   one result (position, velocity) leaves on o_out.
//   Window width and height are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data, by the user only while idle (not enforced); reset gives 800 x 600.
// Operation:
//   A two-entry queue accepts transfers while the back end works.
//   A subject passes the move and wrap states. A neighbor passes the
//   difference, square and test states, and when it is inside the
//   separation range it also waits on the 29-step serial divider.
//   Closing a round runs up to three unit-vector steps, each a normalizing
//   shift (up to 12), a 31-step square root and a 29-step division.
// Reset clears the queue, the sums, the subject and the result valid flag.
// A stalled receiver holds the result in the output register; the back
// end waits before writing the next result, and the queue then fills.
module boid_flocking_update_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bfu_in_if.sink                          i_in,
    bfu_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [bfu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bfu_pkg::WIN_W-1:0]       i_cfg_data
);
    import bfu_pkg::*;

    t_qlink link;
    logic   pop;

    bfu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_link  (link),
        .i_pop   (pop)
    );

    bfu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_link     (link),
        .o_pop      (pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );
endmodule

// ===== hdl/bfu_checker.sv =====
// Port-level checks of the boid flocking update top level, bound to it.
// Depends on bfu_pkg.
module bfu_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input bfu_pkg::t_out_item  out_data
);
    import bfu_pkg::*;

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> in_ready)
        else $error("input not ready after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");
endmodule

bind boid_flocking_update_top bfu_checker u_bfu_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_data  (o_out.data)
);
